>>> hdl/bsd_pkg.sv
// Package for the byte stream deframer: register codes, framing modes,
// configuration and result structs shared by every file of the block.
// No dependencies.
`default_nettype none

package bsd_pkg;

   // Widths fixed by the stream format and the register map
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Framing modes
   typedef enum logic [1:0] {
      MODE_FIXED     = 2'd0,
      MODE_DELIMITED = 2'd1,
      MODE_PREFIXED  = 2'd2,
      MODE_MARKER    = 2'd3
   } mode_type;

   // Register indexes on the control port
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_MODE    = 3'd0,
      REG_FIXED_LENGTH  = 3'd1,
      REG_TERMINATOR    = 3'd2,
      REG_START         = 3'd3,
      REG_LENGTH_OFFSET = 3'd4,
      REG_LENGTH_BYTES  = 3'd5,
      REG_BIG_ENDIAN    = 3'd6,
      REG_MAX_PAYLOAD   = 3'd7
   } csr_index_type;

   // Register values after reset
   localparam logic [LEN_W-1:0]  RST_FIXED_LENGTH  = 16'd0;
   localparam logic [BYTE_W-1:0] RST_TERMINATOR    = 8'd10;
   localparam logic [BYTE_W-1:0] RST_START         = 8'd2;
   localparam logic [3:0]        RST_LENGTH_OFFSET = 4'd0;
   localparam logic [2:0]        RST_LENGTH_BYTES  = 3'd2;
   localparam logic              RST_BIG_ENDIAN    = 1'b1;
   localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD   = 16'd1024;

   typedef struct packed {
      mode_type          frame_mode;
      logic [LEN_W-1:0]  fixed_frame_length;
      logic [BYTE_W-1:0] terminator_byte;
      logic [BYTE_W-1:0] start_byte;
      logic [3:0]        length_field_offset;
      logic [2:0]        length_field_bytes;
      logic              len_msb_first;
      logic [LEN_W-1:0]  max_payload_length;
   } cfg_type;

   // One result word
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              has_data;
      logic              frame_last;
      logic              frame_aborted;
   } rsp_type;

   // Header window status toward the framing core
   typedef struct packed {
      logic             hdr_done;
      logic [LEN_W-1:0] hdr_length;
   } hdr_status_type;

endpackage

`default_nettype wire

>>> hdl/bsd_if.sv
// Valid/ready channel interfaces of the deframer: received bytes, result
// words and register writes.
// Depends on bsd_pkg.
`default_nettype none

interface bsd_req_if import bsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsd_rsp_if import bsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              has_data;
   logic              frame_last;
   logic              frame_aborted;

   modport source (output valid, output payload_byte, output has_data,
                   output frame_last, output frame_aborted, input ready);
   modport sink   (input valid, input payload_byte, input has_data,
                   input frame_last, input frame_aborted, output ready);
endinterface

interface bsd_csr_if import bsd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/bsd_csr.sv
// Configuration registers of the deframer, written through the control
// channel. Depends on bsd_pkg and bsd_if.
`default_nettype none

module bsd_csr import bsd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   bsd_csr_if.sink     csr_chan,
   output cfg_type     cfg,
   output logic        mode_clear
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;
   assign cfg            = cfg_ff;

   // Register decode
   always_comb begin
      cfg_in     = cfg_ff;
      mode_clear = 1'b0;
      if (wr_en) begin
         case (csr_index_type'(csr_chan.index))
            REG_FRAME_MODE: begin
               cfg_in.frame_mode = mode_type'(csr_chan.data[1:0]);
               mode_clear        = 1'b1;
            end
            REG_FIXED_LENGTH:  cfg_in.fixed_frame_length  = csr_chan.data[LEN_W-1:0];
            REG_TERMINATOR:    cfg_in.terminator_byte     = csr_chan.data[BYTE_W-1:0];
            REG_START:         cfg_in.start_byte          = csr_chan.data[BYTE_W-1:0];
            REG_LENGTH_OFFSET: cfg_in.length_field_offset = csr_chan.data[3:0];
            REG_LENGTH_BYTES:  cfg_in.length_field_bytes  = csr_chan.data[2:0];
            REG_BIG_ENDIAN:    cfg_in.len_msb_first       = csr_chan.data[0];
            REG_MAX_PAYLOAD:   cfg_in.max_payload_length  = csr_chan.data[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_mode          <= MODE_FIXED;
         cfg_ff.fixed_frame_length  <= RST_FIXED_LENGTH;
         cfg_ff.terminator_byte     <= RST_TERMINATOR;
         cfg_ff.start_byte          <= RST_START;
         cfg_ff.length_field_offset <= RST_LENGTH_OFFSET;
         cfg_ff.length_field_bytes  <= RST_LENGTH_BYTES;
         cfg_ff.len_msb_first       <= RST_BIG_ENDIAN;
         cfg_ff.max_payload_length  <= RST_MAX_PAYLOAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/bsd_window.sv
// Sliding header window for length prefixed framing: byte store, fill
// count, length field extraction and range check. Depends on bsd_pkg.
`default_nettype none

module bsd_window import bsd_pkg::*; #(
   parameter int MAX_HEADER_BYTES = 16,
   parameter int MAX_LENGTH_BYTES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              mode_clear,
   input  wire logic              win_en,
   input  wire logic [BYTE_W-1:0] rx_byte,
   output hdr_status_type         hdr_status
);

   localparam int IW = (MAX_HEADER_BYTES > 2) ? $clog2(MAX_HEADER_BYTES) : 1;
   localparam int FW = $clog2(MAX_HEADER_BYTES + 1);
   localparam int HW = $clog2(MAX_HEADER_BYTES + 32);
   localparam int LW = MAX_LENGTH_BYTES * BYTE_W;
   localparam int CW = (LW > LEN_W) ? LW : LEN_W;

   logic [BYTE_W-1:0] window_ff [MAX_HEADER_BYTES];
   logic [BYTE_W-1:0] window_in [MAX_HEADER_BYTES];
   logic [BYTE_W-1:0] window_w  [MAX_HEADER_BYTES];
   logic [FW-1:0]     fill_ff;
   logic [FW-1:0]     fill_in;
   logic [FW-1:0]     fill_w;
   logic              push;
   logic [3:0]        nb;
   logic [HW-1:0]     off;
   logic [HW-1:0]     hs;
   logic [LW-1:0]     len_val;
   logic [CW-1:0]     len_ext;
   logic              check;
   logic              bad;

   // Field width and offset, saturated to the window
   always_comb begin
      nb = (cfg.length_field_bytes == 3'd0) ? 4'd1 : {1'b0, cfg.length_field_bytes};
      if (nb > 4'(MAX_LENGTH_BYTES)) nb = 4'(MAX_LENGTH_BYTES);
      if (HW'(nb) > HW'(MAX_HEADER_BYTES)) nb = 4'(MAX_HEADER_BYTES);
      off = HW'(cfg.length_field_offset);
      if (off + HW'(nb) > HW'(MAX_HEADER_BYTES)) off = HW'(MAX_HEADER_BYTES) - HW'(nb);
      hs = off + HW'(nb);
   end

   // Append the new byte at the fill position
   assign push   = fill_ff < FW'(MAX_HEADER_BYTES);
   assign fill_w = fill_ff + FW'(push);

   always_comb begin
      for (int j = 0; j < MAX_HEADER_BYTES; j++) begin
         window_w[j] = (push && fill_ff == FW'(j)) ? rx_byte : window_ff[j];
      end
   end

   // Gather the length field, little endian lanes
   always_comb begin
      logic [HW-1:0] idx;
      idx     = '0;
      len_val = '0;
      for (int k = 0; k < MAX_LENGTH_BYTES; k++) begin
         if (4'(k) < nb) begin
            if (cfg.len_msb_first) idx = off + HW'(nb) - HW'(1) - HW'(k);
            else                   idx = off + HW'(k);
            len_val[k*BYTE_W +: BYTE_W] = window_w[idx[IW-1:0]];
         end
      end
   end

   assign len_ext = CW'(len_val);
   assign check   = win_en && (HW'(fill_w) >= hs);
   assign bad     = (len_ext == '0) || (len_ext > CW'(cfg.max_payload_length));

   assign hdr_status.hdr_done   = check && !bad;
   assign hdr_status.hdr_length = len_ext[LEN_W-1:0];

   // Window and fill update: slide by one on a bad length
   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      if (win_en) begin
         if (check && bad) begin
            for (int j = 0; j < MAX_HEADER_BYTES - 1; j++) begin
               window_in[j] = window_w[j+1];
            end
            window_in[MAX_HEADER_BYTES-1] = window_w[MAX_HEADER_BYTES-1];
            fill_in = fill_w - FW'(1);
         end else begin
            window_in = window_w;
            fill_in   = check ? '0 : fill_w;
         end
      end
      if (mode_clear) fill_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

`default_nettype wire

>>> hdl/bsd_core.sv
// Framing core: per-byte state update for the four framing modes and the
// result word, if any, for each byte. Depends on bsd_pkg.
`default_nettype none

module bsd_core import bsd_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              mode_clear,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  hdr_status_type         hdr_status,
   output logic                   win_en,
   output logic                   res_valid,
   output rsp_type                res
);

   localparam int CTW  = COUNT_BITS + 1;
   localparam int CMPW = (CTW + 1 > LEN_W + 1) ? CTW + 1 : LEN_W + 1;

   logic [BYTE_W-1:0] held_byte_ff,    held_byte_in;
   logic              held_valid_ff,   held_valid_in;
   logic              inside_frame_ff, inside_frame_in;
   logic [CTW-1:0]    byte_count_ff,   byte_count_in;
   logic [LEN_W-1:0]  remaining_ff,    remaining_in;
   logic              in_payload_ff,   in_payload_in;
   logic [CTW:0]      cnt_inc;
   logic [BYTE_W-1:0] held_out;

   assign cnt_inc  = {1'b0, byte_count_ff} + (CTW+1)'(1);
   assign held_out = held_valid_ff ? held_byte_ff : '0;
   assign win_en   = step && (cfg.frame_mode == MODE_PREFIXED) && !in_payload_ff;

   // Next state and result for one byte
   always_comb begin
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      inside_frame_in = inside_frame_ff;
      byte_count_in   = byte_count_ff;
      remaining_in    = remaining_ff;
      in_payload_in   = in_payload_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (step) begin
         case (cfg.frame_mode)
            MODE_FIXED: begin
               if (cfg.fixed_frame_length == '0) begin
                  byte_count_in = '0;
               end else if (CMPW'(cnt_inc) >= CMPW'(cfg.fixed_frame_length)) begin
                  byte_count_in = '0;
                  res_valid     = 1'b1;
                  res           = '{rx_byte, 1'b1, 1'b1, 1'b0};
               end else begin
                  byte_count_in = cnt_inc[CTW-1:0];
                  res_valid     = 1'b1;
                  res           = '{rx_byte, 1'b1, 1'b0, 1'b0};
               end
            end
            MODE_DELIMITED: begin
               if (rx_byte == cfg.terminator_byte) begin
                  res_valid     = 1'b1;
                  res           = '{held_out, held_valid_ff, 1'b1, 1'b0};
                  held_valid_in = 1'b0;
               end else begin
                  res_valid     = held_valid_ff;
                  res           = '{held_out, 1'b1, 1'b0, 1'b0};
                  held_byte_in  = rx_byte;
                  held_valid_in = 1'b1;
               end
            end
            MODE_PREFIXED: begin
               if (in_payload_ff) begin
                  res_valid = 1'b1;
                  if (remaining_ff <= LEN_W'(1)) begin
                     remaining_in  = '0;
                     in_payload_in = 1'b0;
                     res           = '{rx_byte, 1'b1, 1'b1, 1'b0};
                  end else begin
                     remaining_in = remaining_ff - LEN_W'(1);
                     res          = '{rx_byte, 1'b1, 1'b0, 1'b0};
                  end
               end else if (hdr_status.hdr_done) begin
                  remaining_in  = hdr_status.hdr_length;
                  in_payload_in = 1'b1;
               end
            end
            MODE_MARKER: begin
               if (!inside_frame_ff) begin
                  if (rx_byte == cfg.start_byte) begin
                     inside_frame_in = 1'b1;
                     byte_count_in   = '0;
                     held_valid_in   = 1'b0;
                  end
               end else if (rx_byte == cfg.terminator_byte) begin
                  inside_frame_in = 1'b0;
                  byte_count_in   = '0;
                  res_valid       = 1'b1;
                  res             = '{held_out, held_valid_ff, 1'b1, 1'b0};
                  held_valid_in   = 1'b0;
               end else if (CMPW'(byte_count_ff) >= CMPW'(cfg.max_payload_length)) begin
                  // Payload too long: close the frame as aborted
                  inside_frame_in = 1'b0;
                  byte_count_in   = '0;
                  res_valid       = 1'b1;
                  res             = '{held_out, held_valid_ff, 1'b1, 1'b1};
                  held_valid_in   = 1'b0;
               end else begin
                  byte_count_in = cnt_inc[CTW-1:0];
                  res_valid     = held_valid_ff;
                  res           = '{held_out, 1'b1, 1'b0, 1'b0};
                  held_byte_in  = rx_byte;
                  held_valid_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      // A mode write restarts framing
      if (mode_clear) begin
         held_valid_in   = 1'b0;
         inside_frame_in = 1'b0;
         byte_count_in   = '0;
         remaining_in    = '0;
         in_payload_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff   <= 1'b0;
         inside_frame_ff <= 1'b0;
         byte_count_ff   <= '0;
         remaining_ff    <= '0;
         in_payload_ff   <= 1'b0;
      end else begin
         held_valid_ff   <= held_valid_in;
         inside_frame_ff <= inside_frame_in;
         byte_count_ff   <= byte_count_in;
         remaining_ff    <= remaining_in;
         in_payload_ff   <= in_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
   end

endmodule

`default_nettype wire

>>> hdl/byte_stream_deframer.sv
// Byte stream deframer top level: input register, framing core, header
// window, control registers and output register.
// Depends on bsd_pkg, bsd_if, bsd_csr, bsd_window and bsd_core.
//
// Usage:
//   req_chan carries one received byte per word. rsp_chan returns payload
//   bytes with has_data, frame_last and frame_aborted; an empty frame ends
//   with a word whose has_data is 0. A byte may produce no word at all
//   (dropped bytes, headers, markers, the byte held back for last marking).
//   csr_chan writes the eight framing registers; writing frame_mode restarts
//   framing. Write registers only while no byte is in flight.
// Timing:
//   A byte in the input register is framed once the output register has
//   room, and its word is then registered and offered on rsp_chan. One
//   byte per cycle is taken while rsp_chan does not stall; the input and
//   output registers each hold one word; framing state updates once per byte.
// Reset:
//   Synchronous reset empties both registers, restores register defaults
//   and clears framing state. No clearing pass is needed.
// Stall:
//   While rsp_chan.ready is low and a word is waiting, the next byte waits
//   unframed in the input register and req_chan.ready drops once that is full.
`default_nettype none

module byte_stream_deframer import bsd_pkg::*; #(
   parameter int MAX_HEADER_BYTES = 16,
   parameter int MAX_LENGTH_BYTES = 4,
   parameter int COUNT_BITS       = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   bsd_req_if.sink   req_chan,
   bsd_rsp_if.source rsp_chan,
   bsd_csr_if.sink   csr_chan
);

   cfg_type           cfg;
   logic              mode_clear;
   hdr_status_type    hdr_status;
   logic              win_en;
   logic              res_valid;
   rsp_type           res;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_word_ff;
   logic              out_free;
   logic              step;
   logic              req_fire;

   // Handshake: the input register moves on when the output has room
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !step);
   assign out_valid_in = step ? res_valid : (out_valid_ff && !rsp_chan.ready);

   bsd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .cfg        (cfg),
      .mode_clear (mode_clear)
   );

   bsd_window #(
      .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mode_clear (mode_clear),
      .win_en     (win_en),
      .rx_byte    (in_byte_ff),
      .hdr_status (hdr_status)
   );

   bsd_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .mode_clear (mode_clear),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .hdr_status (hdr_status),
      .win_en     (win_en),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      if (req_fire) in_byte_ff <= req_chan.rx_byte;
      if (step && res_valid) out_word_ff <= res;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.payload_byte  = out_word_ff.payload_byte;
   assign rsp_chan.has_data      = out_word_ff.has_data;
   assign rsp_chan.frame_last    = out_word_ff.frame_last;
   assign rsp_chan.frame_aborted = out_word_ff.frame_aborted;

endmodule

`default_nettype wire
